// File: src/hcbd_pkg.sv
package hcbd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned SIZE_W  = 64;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned DIGIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32'd16777216);

  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;

  localparam logic [PHASE_W-1:0] PH_LEAD  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEX   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TRAIL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_EXT   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SKIP1 = 3'd5;
  localparam logic [PHASE_W-1:0] PH_SKIP2 = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd7;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PARSE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ERR_W-1:0]   err_t;

  // bit 4 set: not a hex digit
  function automatic logic [DIGIT_W-1:0] hex_value(input byte_t c);
    logic [DIGIT_W-1:0] d;
    begin
      d = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = DIGIT_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = DIGIT_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = DIGIT_W'(c - 8'h37);
      end
      return d;
    end
  endfunction

endpackage

// File: src/hcbd_in_if.sv
interface hcbd_in_if;
  import hcbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: src/hcbd_out_if.sv
interface hcbd_out_if;
  import hcbd_pkg::*;

  logic  valid;
  logic  ready;
  logic  body_valid;
  byte_t body_byte;
  logic  body_end;
  err_t  fault_code;

  modport source (output valid, output body_valid, output body_byte, output body_end,
                  output fault_code, input ready);
  modport sink (input valid, input body_valid, input body_byte, input body_end,
                input fault_code, output ready);
endinterface

// File: src/http_chunked_body_decoder_core.sv
// Chunked body decoder, one raw byte per transaction.
// byte_in  : raw bytes of an HTTP/1.1 chunked body (valid/ready).
// body_out : one result per input byte: body_valid/body_byte for payload bytes,
//            body_end once the zero-size chunk line has ended, fault_code
//            (1 parse error, 2 body overflow), sticky.
// cfg_wr_en/cfg_wr_data: write the body length limit; write only when idle.
// A result is registered in the output register in the cycle after its byte
// is taken. Throughput: one byte per cycle while the output does not stall; the
// size-line parse, the 64-bit chunk counters and the limit compare all complete
// in the single stage between the decoder state and the output register.
// Stall: while the output register is full and body_out.ready is low,
// byte_in.ready drops and the result holds; taking the result lets the next
// byte in during that same cycle.
// Reset (rst, synchronous): decoder returns to the start of a size line,
// counters and error clear, limit returns to 16777216, output empties.
module http_chunked_body_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  hcbd_in_if.sink                      byte_in,
  hcbd_out_if.source                   body_out,
  input  logic                         cfg_wr_en,
  input  logic [hcbd_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import hcbd_pkg::*;

  logic [LIMIT_W-1:0] max_body_bytes;
  logic [PHASE_W-1:0] phase, phase_next;
  logic               pending_cr, pending_cr_next;
  logic [SIZE_W-1:0]  size_accum, size_accum_next;
  logic [SIZE_W-1:0]  bytes_left, bytes_left_next;
  logic [SIZE_W-1:0]  body_count, body_count_next;
  err_t               error_reg, error_reg_next;

  logic               out_valid;
  logic               out_body_valid, res_valid;
  byte_t              out_body_byte, res_byte;
  logic               out_body_end;
  err_t               out_fault_code;

  logic               accept;
  byte_t              c;
  logic [DIGIT_W-1:0] digit;
  logic               line_end;

  assign byte_in.ready = !out_valid || body_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign c             = byte_in.in_byte;
  assign digit         = hex_value(c);

  always_comb begin
    phase_next      = phase;
    pending_cr_next = pending_cr;
    size_accum_next = size_accum;
    bytes_left_next = bytes_left;
    body_count_next = body_count;
    error_reg_next  = error_reg;
    res_valid       = 1'b0;
    res_byte        = '0;
    line_end        = 1'b0;
    if (error_reg == ERR_NONE) begin
      case (phase)
        PH_LEAD, PH_HEX, PH_TRAIL, PH_EXT: begin
          if (pending_cr) begin
            pending_cr_next = 1'b0;
            if (c == CH_LF) begin
              line_end = 1'b1;
            end else begin
              error_reg_next = ERR_PARSE;
            end
          end else if (c == CH_LF) begin
            line_end = 1'b1;
          end else if (phase == PH_EXT) begin
            phase_next = PH_EXT;
          end else if (c == CH_SEMI) begin
            phase_next = PH_EXT;
          end else if (c == CH_CR) begin
            pending_cr_next = 1'b1;
          end else if (c == CH_SP || c == CH_TAB) begin
            if (phase == PH_HEX) begin
              phase_next = PH_TRAIL;
            end
          end else if (digit[DIGIT_W-1] || phase == PH_TRAIL) begin
            error_reg_next = ERR_PARSE;
          end else begin
            size_accum_next = {size_accum[SIZE_W-5:0], digit[3:0]};
            phase_next      = PH_HEX;
          end
          if (line_end) begin
            pending_cr_next = 1'b0;
            size_accum_next = '0;
            if (size_accum == '0) begin
              phase_next = PH_DONE;
            end else begin
              bytes_left_next = size_accum;
              phase_next      = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res_valid       = 1'b1;
          res_byte        = c;
          body_count_next = body_count + SIZE_W'(1);
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - SIZE_W'(1);
          end
          if (bytes_left[SIZE_W-1:1] == '0) begin
            phase_next = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          phase_next = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_next = PH_LEAD;
          if ((body_count[SIZE_W-1:LIMIT_W] != '0) ||
              (body_count[LIMIT_W-1:0] > max_body_bytes)) begin
            error_reg_next = ERR_OVERFLOW;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_body_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      pending_cr <= 1'b0;
      size_accum <= '0;
      bytes_left <= '0;
      body_count <= '0;
      error_reg  <= ERR_NONE;
    end else if (accept) begin
      phase      <= phase_next;
      pending_cr <= pending_cr_next;
      size_accum <= size_accum_next;
      bytes_left <= bytes_left_next;
      body_count <= body_count_next;
      error_reg  <= error_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (body_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_body_valid <= res_valid;
      out_body_byte  <= res_byte;
      out_body_end   <= (error_reg_next == ERR_NONE) && (phase_next == PH_DONE);
      out_fault_code <= error_reg_next;
    end
  end

  assign body_out.valid      = out_valid;
  assign body_out.body_valid = out_body_valid;
  assign body_out.body_byte  = out_body_byte;
  assign body_out.body_end   = out_body_end;
  assign body_out.fault_code = out_fault_code;

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_reg != ERR_NONE) |=> (error_reg == $past(error_reg)))
    else $error("error code changed after being set");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && error_reg == ERR_NONE) |=> (phase == PH_DONE))
    else $error("decoder left done");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_body_valid) |-> (out_fault_code == ERR_NONE && !out_body_end))
    else $error("payload byte alongside done or error");

endmodule
